>>> sv/vna_pkg.sv
`timescale 1ns / 1ps
package vna_pkg;

  localparam int VERTEX_COUNT_DEF = 1024;

  localparam int IDX_W   = 10;
  localparam int POS_W   = 16;
  localparam int EDGE_W  = 17;
  localparam int CROSS_W = 35;
  localparam int MAG_W   = 34;
  localparam int SMAG_W  = 15;
  localparam int SQ_W    = 30;
  localparam int SUM_W   = 32;
  localparam int Q_W     = 15;
  localparam int ADD_W   = 16;
  localparam int ACC_W   = 24;
  localparam int MUL_W   = 33;
  localparam int PROD_W  = 2 * MUL_W;

  localparam logic [Q_W-1:0] UNIT_Q = 15'd16384;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_TRI   = 2'd1,
    OP_READ  = 2'd2
  } op_t;

endpackage

>>> sv/vna_ram.sv
`timescale 1ns / 1ps
module vna_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/vna_mul.sv
`timescale 1ns / 1ps
module vna_mul (
  input  logic                               clk,
  input  logic signed [vna_pkg::MUL_W-1:0]   a,
  input  logic signed [vna_pkg::MUL_W-1:0]   b,
  output logic signed [vna_pkg::PROD_W-1:0]  p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

>>> sv/vertex_normal_accumulator.sv
`timescale 1ns / 1ps
// Vertex normal accumulator.
// Input channel (in_valid/in_ready) carries one operation per transaction:
//   write  stores a Q8.8 position at index_a and clears its normal.
//   read   returns the Q9.14 normal of index_a on the output channel; the
//          result is registered in S_READ once the output register is free.
//   tri    adds the Q1.14 unit face normal of (index_a, index_b, index_c) to
//          all three vertex normals with saturation. Its steps are position
//          reads, cross product, magnitude, prescale, sum of squares, bitwise
//          unit search (3 components x 15 bits x 3 multiplier passes) and
//          read-modify-write; a degenerate triangle ends after the magnitude
//          step. One shared multiplier serves all products.
// in_ready is high only while no operation is in progress.
// The output channel (out_valid/out_ready) holds the result in a register; a
// stalled receiver holds a following read until the register is free, while
// writes and triangles proceed.
// After reset the normal store is cleared, one entry per cycle, with in_ready low.
module vertex_normal_accumulator #(
  parameter int VERTEX_COUNT = vna_pkg::VERTEX_COUNT_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          op,
  input  logic [vna_pkg::IDX_W-1:0]           index_a,
  input  logic [vna_pkg::IDX_W-1:0]           index_b,
  input  logic [vna_pkg::IDX_W-1:0]           index_c,
  input  logic signed [vna_pkg::POS_W-1:0]    pos_x,
  input  logic signed [vna_pkg::POS_W-1:0]    pos_y,
  input  logic signed [vna_pkg::POS_W-1:0]    pos_z,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [vna_pkg::ACC_W-1:0]    normal_x,
  output logic signed [vna_pkg::ACC_W-1:0]    normal_y,
  output logic signed [vna_pkg::ACC_W-1:0]    normal_z
);

  localparam int AW    = $clog2(VERTEX_COUNT);
  localparam int PW    = 3 * vna_pkg::POS_W;
  localparam int NW    = 3 * vna_pkg::ACC_W;
  localparam int PW1   = vna_pkg::POS_W;
  localparam int EW    = vna_pkg::EDGE_W;
  localparam int CW    = vna_pkg::CROSS_W;
  localparam int MW    = vna_pkg::MAG_W;
  localparam int SMW   = vna_pkg::SMAG_W;
  localparam int QW    = vna_pkg::Q_W;
  localparam int ADW   = vna_pkg::ADD_W;
  localparam int ACW   = vna_pkg::ACC_W;
  localparam int XW    = vna_pkg::MUL_W;
  localparam int SQW   = vna_pkg::SQ_W;
  localparam int SUMW  = vna_pkg::SUM_W;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_READ, S_POS, S_CROSS, S_MAG, S_SHIFT, S_SUMSQ,
    S_UNIT, S_NRD, S_NWR
  } state_t;

  state_t state;
  logic [2:0] step;
  logic [1:0] comp;
  logic [3:0] bitn;
  logic [1:0] phase;
  logic [AW-1:0] ia, ib, ic, clr_addr;
  logic rd_zero;
  logic signed [PW1-1:0] pa [3];
  logic signed [EW-1:0] e1 [3];
  logic signed [EW-1:0] e2 [3];
  logic signed [CW-1:0] cr [3];
  logic [MW-1:0] mag [3];
  logic [2:0] neg;
  logic [SQW-1:0] sq [3];
  logic [SUMW-1:0] sumsq;
  logic [QW-1:0] qv;
  logic signed [ADW-1:0] addv [3];

  logic a_ok, b_ok, c_ok, accept;
  logic pos_we, nrm_we;
  logic [AW-1:0] pos_waddr, pos_raddr, nrm_waddr, nrm_raddr, vert;
  logic [PW-1:0] pos_wdata, pos_rdata;
  logic [NW-1:0] nrm_wdata, nrm_rdata;
  logic signed [XW-1:0] mul_a, mul_b;
  logic signed [vna_pkg::PROD_W-1:0] mul_p;
  logic signed [PW1-1:0] rd_pos [3];
  logic signed [MW:0] abs_in [3];
  logic [QW-1:0] cand, qnew;
  logic [QW:0] tval;
  logic trial_ok, big;
  logic signed [ACW-1:0] sat_res [3];
  logic [2:0] kidx;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == S_IDLE);
  assign a_ok = 32'(index_a) < VERTEX_COUNT;
  assign b_ok = 32'(index_b) < VERTEX_COUNT;
  assign c_ok = 32'(index_c) < VERTEX_COUNT;

  vna_ram #(.WIDTH(PW), .DEPTH(VERTEX_COUNT)) u_pos_ram (
    .clk(clk), .we(pos_we), .waddr(pos_waddr), .wdata(pos_wdata),
    .raddr(pos_raddr), .rdata(pos_rdata)
  );

  vna_ram #(.WIDTH(NW), .DEPTH(VERTEX_COUNT)) u_nrm_ram (
    .clk(clk), .we(nrm_we), .waddr(nrm_waddr), .wdata(nrm_wdata),
    .raddr(nrm_raddr), .rdata(nrm_rdata)
  );

  vna_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

  always_comb begin
    case (comp)
      2'd0:    vert = ia;
      2'd1:    vert = ib;
      default: vert = ic;
    endcase
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rd_pos[i] = $signed(pos_rdata[PW1*i +: PW1]);
      abs_in[i] = cr[i][CW-1] ? -(MW+1)'(cr[i]) : (MW+1)'(cr[i]);
    end
    big = (mag[0][MW-1:SMW] != '0) || (mag[1][MW-1:SMW] != '0) ||
          (mag[2][MW-1:SMW] != '0);
    cand = qv | (QW'(1) << bitn);
    tval = {cand, 1'b0} - (QW+1)'(1);
    trial_ok = mul_p[63:0] <= 64'({sq[comp], 30'd0});
    qnew = trial_ok ? cand : qv;
    kidx = step - 3'd1;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic signed [ACW:0] sum;
      sum = (ACW+1)'($signed(nrm_rdata[ACW*i +: ACW])) + (ACW+1)'(addv[i]);
      if (sum[ACW] != sum[ACW-1]) begin
        sat_res[i] = sum[ACW] ? {1'b1, {(ACW-1){1'b0}}} : {1'b0, {(ACW-1){1'b1}}};
      end else begin
        sat_res[i] = sum[ACW-1:0];
      end
    end
  end

  always_comb begin
    pos_we    = accept && (op == vna_pkg::OP_WRITE) && a_ok;
    pos_waddr = AW'(index_a);
    pos_wdata = {pos_z, pos_y, pos_x};
    case (step)
      3'd0:    pos_raddr = ia;
      3'd1:    pos_raddr = ib;
      default: pos_raddr = ic;
    endcase

    nrm_we    = 1'b0;
    nrm_waddr = vert;
    nrm_wdata = '0;
    nrm_raddr = ia;
    if (state == S_CLEAR) begin
      nrm_we    = 1'b1;
      nrm_waddr = clr_addr;
    end else if (state == S_IDLE) begin
      nrm_we    = pos_we;
      nrm_waddr = AW'(index_a);
      nrm_raddr = AW'(index_a);
    end else if (state == S_NRD) begin
      nrm_raddr = vert;
    end else if (state == S_NWR) begin
      nrm_we    = 1'b1;
      nrm_wdata = {sat_res[2], sat_res[1], sat_res[0]};
    end

    mul_a = '0;
    mul_b = '0;
    if (state == S_CROSS) begin
      case (step)
        3'd0: begin mul_a = XW'(e1[1]); mul_b = XW'(e2[2]); end
        3'd1: begin mul_a = XW'(e1[2]); mul_b = XW'(e2[1]); end
        3'd2: begin mul_a = XW'(e1[2]); mul_b = XW'(e2[0]); end
        3'd3: begin mul_a = XW'(e1[0]); mul_b = XW'(e2[2]); end
        3'd4: begin mul_a = XW'(e1[0]); mul_b = XW'(e2[1]); end
        3'd5: begin mul_a = XW'(e1[1]); mul_b = XW'(e2[0]); end
        default: ;
      endcase
    end else if (state == S_SUMSQ) begin
      case (step)
        3'd0: begin mul_a = XW'(mag[0][SMW-1:0]); mul_b = XW'(mag[0][SMW-1:0]); end
        3'd1: begin mul_a = XW'(mag[1][SMW-1:0]); mul_b = XW'(mag[1][SMW-1:0]); end
        3'd2: begin mul_a = XW'(mag[2][SMW-1:0]); mul_b = XW'(mag[2][SMW-1:0]); end
        default: ;
      endcase
    end else if (state == S_UNIT) begin
      if (phase == 2'd0) begin
        mul_a = XW'(tval);
        mul_b = XW'(tval);
      end else begin
        mul_a = XW'(mul_p[31:0]);
        mul_b = XW'(sumsq);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
      step      <= '0;
      comp      <= '0;
      bitn      <= '0;
      phase     <= '0;
    end else begin
      if (out_valid && out_ready && state != S_READ) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(VERTEX_COUNT - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            ia <= AW'(index_a);
            ib <= AW'(index_b);
            ic <= AW'(index_c);
            case (vna_pkg::op_t'(op))
              vna_pkg::OP_TRI: begin
                if (a_ok && b_ok && c_ok) begin
                  state <= S_POS;
                  step  <= '0;
                end
              end
              vna_pkg::OP_READ: begin
                rd_zero <= !a_ok;
                state   <= S_READ;
              end
              default: ;
            endcase
          end
        end
        S_READ: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            normal_x  <= rd_zero ? '0 : $signed(nrm_rdata[ACW-1:0]);
            normal_y  <= rd_zero ? '0 : $signed(nrm_rdata[2*ACW-1:ACW]);
            normal_z  <= rd_zero ? '0 : $signed(nrm_rdata[3*ACW-1:2*ACW]);
            state     <= S_IDLE;
          end
        end
        S_POS: begin
          for (int i = 0; i < 3; i++) begin
            if (step == 3'd1) pa[i] <= rd_pos[i];
            if (step == 3'd2) e1[i] <= EW'(rd_pos[i]) - EW'(pa[i]);
            if (step == 3'd3) e2[i] <= EW'(rd_pos[i]) - EW'(pa[i]);
          end
          if (step == 3'd3) begin
            state <= S_CROSS;
            step  <= '0;
          end else begin
            step <= step + 3'd1;
          end
        end
        S_CROSS: begin
          step <= step + 3'd1;
          if (step != 3'd0) begin
            if (kidx[0]) begin
              cr[kidx[2:1]] <= cr[kidx[2:1]] - CW'(mul_p);
            end else begin
              cr[kidx[2:1]] <= CW'(mul_p);
            end
          end
          if (step == 3'd6) begin
            state <= S_MAG;
          end
        end
        S_MAG: begin
          for (int i = 0; i < 3; i++) begin
            mag[i] <= abs_in[i][MW-1:0];
            neg[i] <= cr[i][CW-1];
          end
          if (cr[0] == '0 && cr[1] == '0 && cr[2] == '0) begin
            state <= S_IDLE;
          end else begin
            state <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          if (big) begin
            for (int i = 0; i < 3; i++) mag[i] <= mag[i] >> 1;
          end else begin
            state <= S_SUMSQ;
            step  <= '0;
            sumsq <= '0;
          end
        end
        S_SUMSQ: begin
          step <= step + 3'd1;
          if (step != 3'd0) begin
            sq[kidx[1:0]] <= mul_p[SQW-1:0];
            sumsq         <= sumsq + SUMW'(mul_p[SQW-1:0]);
          end
          if (step == 3'd3) begin
            state <= S_UNIT;
            comp  <= '0;
            bitn  <= 4'd14;
            phase <= '0;
            qv    <= '0;
          end
        end
        S_UNIT: begin
          if (phase != 2'd2) begin
            phase <= phase + 2'd1;
          end else begin
            phase <= '0;
            if (bitn != 4'd0) begin
              qv   <= qnew;
              bitn <= bitn - 4'd1;
            end else begin
              addv[comp] <= neg[comp] ? -ADW'(qnew) : ADW'(qnew);
              qv   <= '0;
              bitn <= 4'd14;
              if (comp == 2'd2) begin
                comp  <= '0;
                state <= S_NRD;
              end else begin
                comp <= comp + 2'd1;
              end
            end
          end
        end
        S_NRD: begin
          state <= S_NWR;
        end
        S_NWR: begin
          if (comp == 2'd2) begin
            comp  <= '0;
            state <= S_IDLE;
          end else begin
            comp  <= comp + 2'd1;
            state <= S_NRD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_write_one_cycle: assert property (@(posedge clk) disable iff (rst)
    accept && op == vna_pkg::OP_WRITE |=> in_ready)
    else $error("write did not finish in one cycle");

  a_unit_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_UNIT && phase == 2'd2 |-> qnew <= vna_pkg::UNIT_Q)
    else $error("unit component above one");

  a_prescaled: assert property (@(posedge clk) disable iff (rst)
    state == S_SUMSQ |-> !big)
    else $error("magnitudes not prescaled");

  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !out_valid)
    else $error("result during clearing pass");

  a_tri_no_result: assert property (@(posedge clk) disable iff (rst)
    state == S_NWR && !out_valid |=> !out_valid)
    else $error("triangle produced a result");

endmodule

>>> sim/vna_checker.sv
`timescale 1ns / 1ps
module vna_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  logic [1:0]                       op,
  input  logic [vna_pkg::IDX_W-1:0]        index_a,
  input  logic [vna_pkg::IDX_W-1:0]        index_b,
  input  logic [vna_pkg::IDX_W-1:0]        index_c,
  input  logic signed [vna_pkg::POS_W-1:0] pos_x,
  input  logic signed [vna_pkg::POS_W-1:0] pos_y,
  input  logic signed [vna_pkg::POS_W-1:0] pos_z,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic signed [vna_pkg::ACC_W-1:0] normal_x,
  input  logic signed [vna_pkg::ACC_W-1:0] normal_y,
  input  logic signed [vna_pkg::ACC_W-1:0] normal_z,
  output int                               errors,
  output int                               pending,
  output int                               reads_seen
);

  typedef struct {
    logic signed [vna_pkg::ACC_W-1:0] x;
    logic signed [vna_pkg::ACC_W-1:0] y;
    logic signed [vna_pkg::ACC_W-1:0] z;
  } normal_t;

  longint  position_mem[vna_pkg::VERTEX_COUNT_DEF][3];
  longint  normal_mem[vna_pkg::VERTEX_COUNT_DEF][3];
  normal_t read_queue[$];

  function automatic longint unsigned unit_scale(longint unsigned mag, longint unsigned sumsq);
    longint unsigned lo, hi, mid, t, rhs;
    rhs = (mag * mag) << 30;
    lo  = 0;
    hi  = 64'(vna_pkg::UNIT_Q);
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      t   = 2 * mid - 1;
      if (t * t * sumsq <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic longint sat_acc(longint v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  task automatic add_face_normal(int a, int b, int c);
    longint e1[3], e2[3], cr[3], add[3];
    longint unsigned mag[3], m, s;
    for (int i = 0; i < 3; i++) begin
      e1[i] = position_mem[b][i] - position_mem[a][i];
      e2[i] = position_mem[c][i] - position_mem[a][i];
    end
    cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
    cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
    cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
    m = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = cr[i] < 0 ? -cr[i] : cr[i];
      if (mag[i] > m) m = mag[i];
    end
    if (m == 0) return;
    while (m >= 32768) begin
      for (int i = 0; i < 3; i++) mag[i] >>= 1;
      m >>= 1;
    end
    s = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
    for (int i = 0; i < 3; i++) begin
      add[i] = longint'(unit_scale(mag[i], s));
      if (cr[i] < 0) add[i] = -add[i];
    end
    for (int i = 0; i < 3; i++) begin
      normal_mem[a][i] = sat_acc(normal_mem[a][i] + add[i]);
      normal_mem[b][i] = sat_acc(normal_mem[b][i] + add[i]);
      normal_mem[c][i] = sat_acc(normal_mem[c][i] + add[i]);
    end
  endtask

  initial begin
    errors     = 0;
    reads_seen = 0;
    for (int v = 0; v < vna_pkg::VERTEX_COUNT_DEF; v++)
      for (int i = 0; i < 3; i++) begin
        position_mem[v][i] = 0;
        normal_mem[v][i]   = 0;
      end
  end

  assign pending = read_queue.size();

  always @(posedge clk) begin
    normal_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        reads_seen++;
        if (read_queue.size() == 0) begin
          errors++;
          $display("%0t: unexpected result %0d %0d %0d", $time, normal_x, normal_y,
                   normal_z);
        end else begin
          want = read_queue.pop_front();
          if (normal_x !== want.x) begin
            errors++;
            $display("%0t: normal_x expected %0d actual %0d", $time, want.x, normal_x);
          end
          if (normal_y !== want.y) begin
            errors++;
            $display("%0t: normal_y expected %0d actual %0d", $time, want.y, normal_y);
          end
          if (normal_z !== want.z) begin
            errors++;
            $display("%0t: normal_z expected %0d actual %0d", $time, want.z, normal_z);
          end
        end
      end
      if (in_valid && in_ready) begin
        case (vna_pkg::op_t'(op))
          vna_pkg::OP_WRITE: begin
            position_mem[index_a][0] = longint'(pos_x);
            position_mem[index_a][1] = longint'(pos_y);
            position_mem[index_a][2] = longint'(pos_z);
            for (int i = 0; i < 3; i++) normal_mem[index_a][i] = 0;
          end
          vna_pkg::OP_TRI: add_face_normal(int'(index_a), int'(index_b), int'(index_c));
          vna_pkg::OP_READ: begin
            want.x = vna_pkg::ACC_W'(normal_mem[index_a][0]);
            want.y = vna_pkg::ACC_W'(normal_mem[index_a][1]);
            want.z = vna_pkg::ACC_W'(normal_mem[index_a][2]);
            read_queue.push_back(want);
          end
          default: ;
        endcase
      end
    end
  end

endmodule

>>> sim/vertex_normal_accumulator_tb.sv
`timescale 1ns / 1ps
module vertex_normal_accumulator_tb;

  localparam logic [1:0] OP_SPARE   = 2'd3;
  localparam int         IDLE_LIMIT = 5000;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic [1:0]                       op = vna_pkg::OP_WRITE;
  logic [vna_pkg::IDX_W-1:0]        index_a = '0;
  logic [vna_pkg::IDX_W-1:0]        index_b = '0;
  logic [vna_pkg::IDX_W-1:0]        index_c = '0;
  logic signed [vna_pkg::POS_W-1:0] pos_x = '0;
  logic signed [vna_pkg::POS_W-1:0] pos_y = '0;
  logic signed [vna_pkg::POS_W-1:0] pos_z = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic signed [vna_pkg::ACC_W-1:0] normal_x, normal_y, normal_z;

  int errors, pending, reads_seen;
  int send_idle_pct, recv_idle_pct;
  int hold_req;
  int hold_left;
  int idle_cycles;
  int sent;
  bit written[vna_pkg::VERTEX_COUNT_DEF];
  int written_list[$];

  always #5 clk = ~clk;

  vertex_normal_accumulator i_dut (.*);

  vna_checker i_checker (.*);

  // receiver: random stalls plus a counted hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_req > 0 && hold_left == 0) begin
      hold_left <= hold_req;
      hold_req  = 0;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send(logic [1:0] o, int a, int b, int c, int x, int y, int z);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= o;
    index_a  <= vna_pkg::IDX_W'(a);
    index_b  <= vna_pkg::IDX_W'(b);
    index_c  <= vna_pkg::IDX_W'(c);
    pos_x    <= vna_pkg::POS_W'(x);
    pos_y    <= vna_pkg::POS_W'(y);
    pos_z    <= vna_pkg::POS_W'(z);
    forever begin
      @(negedge clk);
      if (in_ready) break;
    end
    @(posedge clk);
    sent++;
    if (o == vna_pkg::OP_WRITE && !written[a]) begin
      written[a] = 1'b1;
      written_list.push_back(a);
    end
  endtask

  task automatic put_vertex(int v, int x, int y, int z);
    send(vna_pkg::OP_WRITE, v, $urandom, $urandom, x, y, z);
  endtask

  task automatic face(int a, int b, int c);
    send(vna_pkg::OP_TRI, a, b, c, $urandom, $urandom, $urandom);
  endtask

  task automatic fetch(int v);
    send(vna_pkg::OP_READ, v, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic int pick_written();
    return written_list[$urandom_range(written_list.size() - 1)];
  endfunction

  task automatic random_item();
    int r, a, b, c;
    r = $urandom_range(99);
    if (r < 25) begin
      if ($urandom_range(3) == 0)
        put_vertex($urandom_range(1023), $urandom_range(2047) - 1024,
                   $urandom_range(2047) - 1024, $urandom_range(2047) - 1024);
      else
        put_vertex($urandom_range(1023), $urandom, $urandom, $urandom);
    end else if (r < 70) begin
      a = pick_written();
      b = pick_written();
      c = pick_written();
      if ($urandom_range(9) == 0) b = a;
      face(a, b, c);
    end else if (r < 95) begin
      fetch($urandom_range(3) == 0 ? $urandom_range(1023) : pick_written());
    end else begin
      send(OP_SPARE, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req      = 0;
    idle_cycles   = 0;
    sent          = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: unit faces both windings, extremes, degenerate cases
    put_vertex(0, 0, 0, 0);
    put_vertex(1, 256, 0, 0);
    put_vertex(2, 0, 256, 0);
    put_vertex(3, -32768, 32767, -32768);
    put_vertex(1023, 32767, 32767, 32767);
    put_vertex(4, 0, 0, 0);
    face(0, 1, 2);
    face(0, 2, 1);
    face(0, 0, 1);
    face(0, 4, 1);
    face(1023, 3, 0);
    face(3, 1023, 2);
    fetch(0);
    fetch(1);
    fetch(3);
    fetch(1023);
    fetch(500);
    send(OP_SPARE, 1023, 1023, 1023, -1, -1, -1);
    put_vertex(1023, -32768, 0, 32767);
    fetch(1023);
    drain();

    // saturate x low and y high on the same vertices
    put_vertex(10, 0, 0, 0);
    put_vertex(11, 0, 0, 1);
    put_vertex(12, 1, 1, 0);
    repeat (730) face(10, 11, 12);
    fetch(10);
    fetch(12);
    drain();

    for (int v = 20; v < 36; v++) put_vertex(v, $urandom, $urandom, $urandom);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = phase == 0 ? 29 : phase == 1 ? 72 : 0;
      recv_idle_pct = phase == 0 ? 72 : phase == 1 ? 29 : 0;
      for (int n = 0; n < 22; n++) begin
        if (phase == 0 && n == 5) begin
          hold_req = 400;
          repeat (12) fetch(pick_written());
        end
        if (phase == 1 && n == 11) drain();
        random_item();
      end
    end
    drain();

    $display("Sent %0d transactions: extreme and degenerate faces, saturation both ways,",
             sent);
    $display("%0d reads checked across three stall mixes with a long receiver hold-off.",
             reads_seen);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

>>> files.f
sv/vna_pkg.sv
sv/vna_ram.sv
sv/vna_mul.sv
sv/vertex_normal_accumulator.sv
sim/vna_checker.sv
sim/vertex_normal_accumulator_tb.sv
